[design/lbs_pkg.sv]
// shared types, codes and helpers for the linear blend skinning block
// no dependencies; imported by every lbs module
`default_nettype none

package lbs_pkg;

  // request codes
  localparam logic REQ_WRITE  = 1'b0;
  localparam logic REQ_VERTEX = 1'b1;

  localparam logic [7:0] IDENTITY_INDEX = 8'hFF;
  localparam int unsigned MAT_ELEMS = 12;

  // one input item
  typedef struct packed {
    logic               req_type;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] nrm_x;
    logic signed [31:0] nrm_y;
    logic signed [31:0] nrm_z;
    logic [63:0]        blend_weights;
    logic [31:0]        blend_indices;
    logic [7:0]         bone_slot;
    logic [3:0]         matrix_element;
    logic signed [31:0] matrix_value;
  } in_item_t;

  // one result item
  typedef struct packed {
    logic signed [31:0] out_pos_x;
    logic signed [31:0] out_pos_y;
    logic signed [31:0] out_pos_z;
    logic signed [31:0] out_nrm_x;
    logic signed [31:0] out_nrm_y;
    logic signed [31:0] out_nrm_z;
    logic               bad_index;
  } out_item_t;

  // one bone influence travelling down the pipeline
  typedef struct packed {
    logic [2:0][31:0] pos;
    logic [2:0][31:0] nrm;
    logic [15:0]      w;
    logic             ident;
    logic             bad;
    logic             first;
    logic             last;
  } infl_t;

  // clamp to the signed 32-bit range
  function automatic logic [31:0] sat32(input logic signed [51:0] x);
    logic [31:0] r;
    if (x > 52'sd2147483647) begin
      r = 32'h7FFF_FFFF;
    end else if (x < -52'sd2147483648) begin
      r = 32'h8000_0000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[design/lbs_palette.sv]
// bone palette: twelve banks, one per matrix element, each one entry per bone
// uses lbs_pkg; written one element per item, read one whole matrix per cycle
`default_nettype none

module lbs_palette #(
  parameter int PALETTE_BONES = 128,
  parameter int ADDR_W = (PALETTE_BONES > 1) ? $clog2(PALETTE_BONES) : 1
) (
  input  wire logic                 clk,
  input  wire logic                 wr_en,
  input  wire logic [3:0]           wr_elem,
  input  wire logic [ADDR_W-1:0]    wr_slot,
  input  wire logic [31:0]          wr_data,
  input  wire logic                 rd_en,
  input  wire logic [ADDR_W-1:0]    rd_addr,
  output logic      [11:0][31:0]    rd_data
);
  import lbs_pkg::*;

  for (genvar e = 0; e < MAT_ELEMS; e++) begin : g_bank
    logic [31:0] mem [PALETTE_BONES];

    // write one element, registered read of the whole entry
    always_ff @(posedge clk) begin
      if (wr_en && wr_elem == 4'(e)) begin
        mem[wr_slot] <= wr_data;
      end
      if (rd_en) begin
        rd_data[e] <= mem[rd_addr];
      end
    end
  end

endmodule

`default_nettype wire

[design/lbs_xform.sv]
// matrix transform of one influence: products stage, then row sums with clamp
// uses lbs_pkg (infl_t, sat32)
`default_nettype none

module lbs_xform (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                en,
  input  wire logic                in_valid,
  input  wire lbs_pkg::infl_t      in_side,
  input  wire logic [11:0][31:0]   in_mat,
  output logic                     out_valid,
  output lbs_pkg::infl_t           out_side,
  output logic [2:0][31:0]         tp,
  output logic [2:0][31:0]         tn
);
  import lbs_pkg::*;

  logic signed [47:0] pp [3][3];
  logic signed [47:0] np [3][3];
  logic signed [31:0] trans [3];
  logic               s2_valid;
  infl_t              s2_side;

  // stage 2 control
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (en) begin
      s2_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_side <= in_side;
    end
  end

  // stage 2: element times coordinate, floored to Q16.16
  for (genvar r = 0; r < 3; r++) begin : g_row
    for (genvar c = 0; c < 3; c++) begin : g_col
      logic signed [63:0] pprod;
      logic signed [63:0] nprod;
      assign pprod = $signed(in_mat[4*r+c]) * $signed(in_side.pos[c]);
      assign nprod = $signed(in_mat[4*r+c]) * $signed(in_side.nrm[c]);
      always_ff @(posedge clk) begin
        if (en) begin
          pp[r][c] <= pprod[63:16];
          np[r][c] <= nprod[63:16];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        trans[r] <= $signed(in_mat[4*r+3]);
      end
    end

    // stage 3: row sums, clamp, identity bypass
    logic signed [49:0] psum;
    logic signed [49:0] nsum;
    assign psum = 50'(pp[r][0]) + 50'(pp[r][1]) + 50'(pp[r][2]) + 50'(trans[r]);
    assign nsum = 50'(np[r][0]) + 50'(np[r][1]) + 50'(np[r][2]);

    always_ff @(posedge clk) begin
      if (en) begin
        tp[r] <= s2_side.ident ? s2_side.pos[r] : sat32(52'(psum));
        tn[r] <= s2_side.ident ? s2_side.nrm[r] : sat32(52'(nsum));
      end
    end
  end

  // stage 3 control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_side <= s2_side;
    end
  end

endmodule

`default_nettype wire

[design/lbs_blend.sv]
// weighting and accumulation over the influences of one vertex, then rounding
// uses lbs_pkg (infl_t, out_item_t, sat32)
`default_nettype none

module lbs_blend (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              en,
  input  wire logic              in_valid,
  input  wire lbs_pkg::infl_t    in_side,
  input  wire logic [2:0][31:0]  tp,
  input  wire logic [2:0][31:0]  tn,
  output logic                   done,
  output lbs_pkg::out_item_t     res_next
);
  import lbs_pkg::*;

  logic signed [48:0] wp [6];
  logic signed [50:0] acc [6];
  logic signed [50:0] acc_next [6];
  logic signed [31:0] rnd [6];
  logic               s4_valid;
  logic               s4_first;
  logic               s4_last;
  logic               s4_bad;
  logic               bad_acc;
  logic               bad_acc_next;

  // stage 4: value times weight, exact
  for (genvar j = 0; j < 6; j++) begin : g_lane
    logic signed [31:0] v;
    assign v = (j < 3) ? $signed(tp[j % 3]) : $signed(tn[j % 3]);

    always_ff @(posedge clk) begin
      if (en) begin
        wp[j] <= v * $signed({1'b0, in_side.w});
      end
    end

    // stage 5: running sum, restarted by the first influence
    assign acc_next[j] = (s4_first ? 51'sd0 : acc[j]) + 51'(wp[j]);

    always_ff @(posedge clk) begin
      if (en && s4_valid) begin
        acc[j] <= acc_next[j];
      end
    end

    // floor to Q16.16 and clamp
    assign rnd[j] = sat32(52'(acc[j] >>> 15));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
      done     <= 1'b0;
    end else if (en) begin
      s4_valid <= in_valid;
      done     <= s4_valid && s4_last;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_first <= in_side.first;
      s4_last  <= in_side.last;
      s4_bad   <= in_side.bad;
    end
  end

  assign bad_acc_next = (s4_first ? 1'b0 : bad_acc) | s4_bad;

  always_ff @(posedge clk) begin
    if (en && s4_valid) begin
      bad_acc <= bad_acc_next;
    end
  end

  // result assembly
  always_comb begin
    res_next.out_pos_x = rnd[0];
    res_next.out_pos_y = rnd[1];
    res_next.out_pos_z = rnd[2];
    res_next.out_nrm_x = rnd[3];
    res_next.out_nrm_y = rnd[4];
    res_next.out_nrm_z = rnd[5];
    res_next.bad_index = bad_acc;
  end

endmodule

`default_nettype wire

[design/linear_blend_skinning.sv]
// Linear blend skinning with a palette of 3x4 bone matrices.
// One input channel (req_valid/req_ready/req) carries two kinds of item:
// a palette write (one matrix element, no result) or a vertex to skin.
// Each vertex gives one result on res_valid/res_ready/res.
// A palette write does not occupy the issue stage. A vertex holds the issue
// stage for its BLEND_BONES influences, one bone influence per cycle while res
// is not stalled; the single palette read of a whole matrix per cycle sets
// that pace. The next item is taken in the cycle that the last influence of
// the current vertex issues.
// From vertex acceptance to result, the path runs through palette read,
// products, row sums, weighting, accumulation and rounding.
// Reset clears all valid bits and the issue stage; palette contents are
// undefined until written. A stall on res freezes the whole pipeline, the
// result register holds, and req_ready drops until res is taken.
// uses lbs_pkg, lbs_palette, lbs_xform, lbs_blend
`default_nettype none

module linear_blend_skinning #(
  parameter int PALETTE_BONES = 128,
  parameter int BLEND_BONES   = 4
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_ready,
  input  wire lbs_pkg::in_item_t req,
  output logic               res_valid,
  input  wire logic          res_ready,
  output lbs_pkg::out_item_t res
);
  import lbs_pkg::*;

  localparam int ADDR_W = (PALETTE_BONES > 1) ? $clog2(PALETTE_BONES) : 1;

  logic              adv;
  logic              busy;
  logic [1:0]        k;
  in_item_t          vtx;
  logic              last_k;
  logic [3:0][7:0]   idxs;
  logic [3:0][15:0]  wts;
  logic [7:0]        idx;
  logic              pal_hit;
  infl_t             issue;
  logic              acc_vtx;
  logic              wr_en;
  logic [11:0][31:0] mat;
  logic              s1_valid;
  infl_t             s1_side;
  logic              s3_valid;
  infl_t             s3_side;
  logic [2:0][31:0]  tp;
  logic [2:0][31:0]  tn;
  logic              done;
  out_item_t         res_next;

  // whole pipeline moves when the result register is free or being taken
  assign adv       = !res_valid || res_ready;
  assign last_k    = (k == 2'(BLEND_BONES - 1));
  assign req_ready = adv && (!busy || last_k);
  assign acc_vtx   = req_valid && req_ready && req.req_type == REQ_VERTEX;
  assign wr_en     = req_valid && req_ready && req.req_type == REQ_WRITE
                     && {1'b0, req.bone_slot} < 9'(PALETTE_BONES)
                     && req.matrix_element < 4'(MAT_ELEMS);

  // issue stage: select one influence of the held vertex
  assign idxs    = vtx.blend_indices;
  assign wts     = vtx.blend_weights;
  assign idx     = idxs[k];
  assign pal_hit = idx != IDENTITY_INDEX && {1'b0, idx} < 9'(PALETTE_BONES);

  always_comb begin
    issue.pos   = {vtx.pos_z, vtx.pos_y, vtx.pos_x};
    issue.nrm   = {vtx.nrm_z, vtx.nrm_y, vtx.nrm_x};
    issue.w     = wts[k];
    issue.ident = !pal_hit;
    issue.bad   = !pal_hit && idx != IDENTITY_INDEX;
    issue.first = (k == 2'd0);
    issue.last  = last_k;
  end

  // issue sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      k    <= 2'd0;
    end else if (adv) begin
      if (acc_vtx) begin
        busy <= 1'b1;
        k    <= 2'd0;
      end else if (busy && last_k) begin
        busy <= 1'b0;
      end else if (busy) begin
        k <= k + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc_vtx) begin
      vtx <= req;
    end
  end

  // palette, read at the issue stage
  lbs_palette #(
    .PALETTE_BONES(PALETTE_BONES),
    .ADDR_W       (ADDR_W)
  ) u_palette (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_elem(req.matrix_element),
    .wr_slot(req.bone_slot[ADDR_W-1:0]),
    .wr_data(req.matrix_value),
    .rd_en  (adv),
    .rd_addr(idx[ADDR_W-1:0]),
    .rd_data(mat)
  );

  // stage 1 alongside the palette read
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= busy;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_side <= issue;
    end
  end

  lbs_xform u_xform (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .in_valid (s1_valid),
    .in_side  (s1_side),
    .in_mat   (mat),
    .out_valid(s3_valid),
    .out_side (s3_side),
    .tp       (tp),
    .tn       (tn)
  );

  lbs_blend u_blend (
    .clk     (clk),
    .rst     (rst),
    .en      (adv),
    .in_valid(s3_valid),
    .in_side (s3_side),
    .tp      (tp),
    .tn      (tn),
    .done    (done),
    .res_next(res_next)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (adv) begin
      res_valid <= done;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res <= res_next;
    end
  end

  // checks
  a_k_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> (k <= 2'(BLEND_BONES - 1)))
    else $error("influence counter past last bone");

  a_stall_freeze: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(s1_valid) && $stable(k) && $stable(busy))
    else $error("pipeline moved during a stall");

  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    req_ready |-> (!res_valid || res_ready))
    else $error("item taken while result stalled");

endmodule

`default_nettype wire

[tb/linear_blend_skinning_tb.sv]
// self-checking testbench for linear_blend_skinning: palette loads and vertex skinning
// depends on lbs_pkg and the linear_blend_skinning top level
`default_nettype none

module linear_blend_skinning_tb;
  import lbs_pkg::*;

  localparam int NUM_BONES   = 128;
  localparam int NUM_INFL    = 4;
  localparam int RAND_ITEMS  = 1400;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_WAIT  = 40;

  logic      clk;
  logic      rst;
  logic      req_valid;
  logic      req_ready;
  in_item_t  req;
  logic      res_valid;
  logic      res_ready;
  out_item_t res;

  linear_blend_skinning #(
    .PALETTE_BONES(NUM_BONES),
    .BLEND_BONES  (NUM_INFL)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req      (req),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res      (res)
  );

  // predictor state
  logic signed [31:0] palette_mem [NUM_BONES*MAT_ELEMS];
  logic [11:0]        elem_written [NUM_BONES];
  out_item_t          skinned_q [$];
  int                 mismatches;
  bit                 no_idle;
  int                 cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // one idle decision, roughly a third of the time
  function automatic bit take_idle();
    return !no_idle && ($urandom_range(0, 99) < 34);
  endfunction

  function automatic longint clamp32(input longint x);
    longint r;
    if (x > 64'sd2147483647) r = 64'sd2147483647;
    else if (x < -64'sd2147483648) r = -64'sd2147483648;
    else r = x;
    return r;
  endfunction

  // one matrix row times (v, w)
  function automatic longint bone_row(input int bone, input int row, input longint v[3],
                                      input bit with_t);
    longint acc;
    longint e;
    acc = 0;
    for (int c = 0; c < 3; c++) begin
      e = longint'(palette_mem[bone*MAT_ELEMS + row*4 + c]);
      acc += (e * v[c]) >>> 16;
    end
    if (with_t) acc += longint'(palette_mem[bone*MAT_ELEMS + row*4 + 3]);
    return clamp32(acc);
  endfunction

  // expected result of one vertex item
  function automatic out_item_t skin_vertex(input in_item_t it);
    longint    p[3];
    longint    n[3];
    longint    ap[3];
    longint    an[3];
    longint    w;
    longint    tp;
    longint    tn;
    int        idx;
    bit        ident;
    out_item_t o;
    p[0] = longint'(it.pos_x); p[1] = longint'(it.pos_y); p[2] = longint'(it.pos_z);
    n[0] = longint'(it.nrm_x); n[1] = longint'(it.nrm_y); n[2] = longint'(it.nrm_z);
    for (int r = 0; r < 3; r++) begin
      ap[r] = 0;
      an[r] = 0;
    end
    o = '0;
    for (int k = 0; k < NUM_INFL; k++) begin
      w     = longint'(it.blend_weights[16*k +: 16]);
      idx   = int'(it.blend_indices[8*k +: 8]);
      ident = (idx == IDENTITY_INDEX) || (idx >= NUM_BONES);
      if (idx != IDENTITY_INDEX && idx >= NUM_BONES) o.bad_index = 1'b1;
      for (int r = 0; r < 3; r++) begin
        tp = ident ? p[r] : bone_row(idx, r, p, 1'b1);
        tn = ident ? n[r] : bone_row(idx, r, n, 1'b0);
        ap[r] += tp * w;
        an[r] += tn * w;
      end
    end
    o.out_pos_x = 32'(clamp32(ap[0] >>> 15));
    o.out_pos_y = 32'(clamp32(ap[1] >>> 15));
    o.out_pos_z = 32'(clamp32(ap[2] >>> 15));
    o.out_nrm_x = 32'(clamp32(an[0] >>> 15));
    o.out_nrm_y = 32'(clamp32(an[1] >>> 15));
    o.out_nrm_z = 32'(clamp32(an[2] >>> 15));
    return o;
  endfunction

  // send one item, called at a rising edge; returns at the edge that took it
  task automatic send_item(input in_item_t it);
    if (take_idle()) begin
      req_valid <= 1'b0;
      do @(posedge clk); while (take_idle());
    end
    req_valid <= 1'b1;
    req       <= it;
    @(negedge clk);
    while (!req_ready) @(negedge clk);
    @(posedge clk);
    // item taken at this edge: update the predictor in order
    if (it.req_type == REQ_WRITE) begin
      if (it.bone_slot < NUM_BONES && it.matrix_element < MAT_ELEMS) begin
        palette_mem[it.bone_slot*MAT_ELEMS + it.matrix_element] = it.matrix_value;
        elem_written[it.bone_slot][it.matrix_element] = 1'b1;
      end
    end else begin
      skinned_q.push_back(skin_vertex(it));
    end
  endtask

  function automatic logic [31:0] rand_q16();
    logic [31:0] v;
    case ($urandom_range(0, 5))
      0:       v = 32'h7FFF_FFFF;
      1:       v = 32'h8000_0000;
      2, 3:    v = 32'($signed($urandom_range(0, 262143)) - 131072);
      default: v = $urandom;
    endcase
    return v;
  endfunction

  function automatic bit bone_full(input int b);
    return &elem_written[b];
  endfunction

  function automatic in_item_t rand_noise();
    logic [351:0] raw;
    in_item_t     it;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
           $urandom, $urandom, $urandom, $urandom};
    it  = raw[$bits(in_item_t)-1:0];
    return it;
  endfunction

  task automatic write_elem(input int slot, input int el, input logic [31:0] val);
    in_item_t it;
    it                = rand_noise();
    it.req_type       = REQ_WRITE;
    it.bone_slot      = 8'(slot);
    it.matrix_element = 4'(el);
    it.matrix_value   = val;
    send_item(it);
  endtask

  task automatic send_vertex(input logic [31:0] px, py, pz, nx, ny, nz,
                             input logic [63:0] wts, input logic [31:0] ids);
    in_item_t it;
    it               = rand_noise();
    it.req_type      = REQ_VERTEX;
    it.pos_x         = px; it.pos_y = py; it.pos_z = pz;
    it.nrm_x         = nx; it.nrm_y = ny; it.nrm_z = nz;
    it.blend_weights = wts;
    it.blend_indices = ids;
    send_item(it);
  endtask

  // identity and out-of-palette indices with extreme fields
  task automatic test_identity_extremes();
    send_vertex(32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000, 32'h8000_0000,
                32'h7FFF_FFFF, 32'h0, {4{16'hFFFF}}, 32'hFFFF_FFFF);
    send_vertex(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                32'h7FFF_FFFF, 32'h7FFF_FFFF, {4{16'h8000}}, 32'hFFFF_FFFF);
    send_vertex(32'h0001_0000, 32'hFFFF_0000, 32'h1234_5678, 32'h0, 32'h1, 32'hFFFF_FFFF,
                64'h0, 32'hFFFF_FFFF);
    send_vertex(32'h0003_8000, 32'hFFFF_FFFF, 32'h1, 32'h0002_0000, 32'h8000_0001, 32'h5,
                64'h8000_0000_0000_0000, 32'h80FF_FEFF);
    send_vertex($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                64'h2000_2000_2000_2000, 32'hFE80_81FF);
  endtask

  // writes outside the palette or past element 11 leave it unchanged
  task automatic test_ignored_writes();
    write_elem(NUM_BONES, 0, 32'h7FFF_FFFF);
    write_elem(254, 5, 32'h8000_0000);
    write_elem(3, 12, 32'h1234_5678);
    write_elem(0, 15, 32'hFFFF_FFFF);
  endtask

  // load bones 0 and NUM_BONES-1 fully with value patterns, then skin through them
  task automatic test_bone_matrix();
    for (int e = 0; e < MAT_ELEMS; e++)
      write_elem(0, e, (e % 5 == 0) ? 32'h0001_0000 : 32'h0000_8000);
    for (int e = 0; e < MAT_ELEMS; e++)
      write_elem(NUM_BONES-1, e, (e % 2) ? 32'h7FFF_FFFF : 32'h8000_0000);
    send_vertex(32'h0002_0000, 32'hFFFF_0000, 32'h0000_4000, 32'h0001_0000, 32'h0, 32'h8000_0000,
                64'h0000_0000_4000_4000, {8'hFF, 8'hFF, 8'h7F, 8'h00});
    send_vertex(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                32'h7FFF_FFFF, {4{16'hFFFF}}, {4{8'h7F}});
    send_vertex(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h1, 32'h1, 32'h1,
                64'h1111_2222_3333_4444, {8'h00, 8'hC8, 8'h7F, 8'h00});
  endtask

  function automatic logic [7:0] rand_index();
    int b;
    int pick;
    logic [7:0] r;
    pick = $urandom_range(0, 99);
    if (pick < 60) begin
      do b = $urandom_range(0, 15); while (!bone_full(b));
      if ($urandom_range(0, 3) == 0 && bone_full(NUM_BONES-1)) b = NUM_BONES-1;
      r = 8'(b);
    end else if (pick < 80) begin
      r = IDENTITY_INDEX;
    end else begin
      r = 8'($urandom_range(NUM_BONES, 254));
    end
    return r;
  endfunction

  // mixed palette updates and vertices with random content
  task automatic test_random_mix(input int count);
    int pick;
    logic [31:0] ids;
    // make a handful of bones usable
    for (int b = 1; b < 8; b++)
      for (int e = 0; e < MAT_ELEMS; e++)
        write_elem(b, e, rand_q16());
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 20) begin
        write_elem($urandom_range(0, 15), $urandom_range(0, MAT_ELEMS-1), rand_q16());
      end else if (pick < 25) begin
        if ($urandom_range(0, 1)) write_elem($urandom_range(NUM_BONES, 254),
                                             $urandom_range(0, 15), $urandom);
        else write_elem($urandom_range(0, 254), $urandom_range(MAT_ELEMS, 15), $urandom);
      end else begin
        for (int k = 0; k < NUM_INFL; k++) ids[8*k +: 8] = rand_index();
        send_vertex(rand_q16(), rand_q16(), rand_q16(), rand_q16(), rand_q16(), rand_q16(),
                    {16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom)}, ids);
      end
    end
  endtask

  // back-to-back stretch with no idling on either side
  task automatic test_burst();
    no_idle = 1'b1;
    test_random_mix(300);
    no_idle = 1'b0;
  endtask

  // result checking and sink stalls
  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      res_ready <= 1'b0;
    end else begin
      res_ready <= !take_idle();
      if (res_valid && res_ready) begin
        if (skinned_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result item %p", res);
        end else begin
          want = skinned_q.pop_front();
          if (res.out_pos_x !== want.out_pos_x || res.out_pos_y !== want.out_pos_y ||
              res.out_pos_z !== want.out_pos_z || res.out_nrm_x !== want.out_nrm_x ||
              res.out_nrm_y !== want.out_nrm_y || res.out_nrm_z !== want.out_nrm_z ||
              res.bad_index !== want.bad_index) begin
            mismatches++;
            if (mismatches <= 10) $display("mismatch: expected %p actual %p", want, res);
          end
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    rst        = 1'b1;
    req_valid  = 1'b0;
    req        = '0;
    mismatches = 0;
    no_idle    = 1'b0;
    cycles     = 0;
    for (int b = 0; b < NUM_BONES; b++) elem_written[b] = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_identity_extremes();
    test_ignored_writes();
    test_bone_matrix();
    test_random_mix(RAND_ITEMS - 600);
    test_burst();
    test_random_mix(100);
    req_valid <= 1'b0;
    while (skinned_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatches == 0 && skinned_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
